>>> src/pbb_pkg.sv
// ---------------------------------------------------------------------------
// pbb_pkg - shared types and constants for the pulsed actuator controller
// Request and action codes, field widths, configuration register map and the
// configuration and item structures used across the block.
// ---------------------------------------------------------------------------
`default_nettype none

package pbb_pkg;

   // field widths
   localparam int FB_BITS   = 12;
   localparam int HYST_BITS = 10;
   localparam int SLOT_BITS = 5;
   localparam int CMP_BITS  = FB_BITS + 2;   // signed room for position +/- hysteresis
   localparam int LANES     = 2;             // gate outputs exist for two actuators
   localparam int ACTUATORS_DEF = 2;

   // packed port widths
   localparam int REQ_DATA_BITS = 64;
   localparam int REQ_USER_BITS = 3;
   localparam int RSP_DATA_BITS = 16;
   localparam int RSP_FIELDS    = 10;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 12;

   // request kinds
   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_ENABLE  = 2'd1,
      REQ_DISABLE = 2'd2,
      REQ_ESTOP   = 2'd3
   } req_kind_type;

   // bridge actions; hold also means all gates off
   typedef enum logic [1:0] {
      ACT_HOLD     = 2'd0,
      ACT_EXTEND   = 2'd1,
      ACT_CONTRACT = 2'd2
   } action_type;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_HYSTERESIS     = 3'd0,
      CSR_FB_FLOOR       = 3'd1,
      CSR_FB_CEILING     = 3'd2,
      CSR_EXTEND_FIRST   = 3'd3,
      CSR_EXTEND_SECOND  = 3'd4,
      CSR_CONTRACT_FIRST = 3'd5,
      CSR_CONTRACT_SECOND= 3'd6,
      CSR_HOLD_SLOTS     = 3'd7
   } csr_addr_type;

   // reset values of the configuration registers
   localparam logic [HYST_BITS-1:0] HYST_RST          = 10'd16;
   localparam logic [FB_BITS-1:0]   FLOOR_RST         = 12'd0;
   localparam logic [FB_BITS-1:0]   CEILING_RST       = 12'd4095;
   localparam logic [SLOT_BITS-1:0] EXTEND_FIRST_RST  = 5'd20;
   localparam logic [SLOT_BITS-1:0] EXTEND_SECOND_RST = 5'd7;
   localparam logic [SLOT_BITS-1:0] CONTR_FIRST_RST   = 5'd5;
   localparam logic [SLOT_BITS-1:0] CONTR_SECOND_RST  = 5'd7;
   localparam logic [SLOT_BITS-1:0] HOLD_SLOTS_RST    = 5'd6;

   typedef struct packed {
      logic [HYST_BITS-1:0] hysteresis;
      logic [FB_BITS-1:0]   fb_floor;
      logic [FB_BITS-1:0]   fb_ceiling;
      logic [SLOT_BITS-1:0] extend_first;
      logic [SLOT_BITS-1:0] extend_second;
      logic [SLOT_BITS-1:0] contract_first;
      logic [SLOT_BITS-1:0] contract_second;
      logic [SLOT_BITS-1:0] hold_slots;
   } cfg_type;

   // one captured request item
   typedef struct packed {
      req_kind_type                  kind;
      logic                          sel;
      logic [FB_BITS-1:0]            new_target;
      logic [FB_BITS-1:0]            new_min;
      logic [FB_BITS-1:0]            new_max;
      logic [LANES-1:0][FB_BITS-1:0] feedback;
   } item_type;

   // unsigned position into the signed compare domain
   function automatic logic signed [CMP_BITS-1:0] to_cmp(input logic [FB_BITS-1:0] x);
      return $signed({2'b00, x});
   endfunction

   function automatic logic signed [CMP_BITS-1:0] hyst_cmp(input logic [HYST_BITS-1:0] x);
      return $signed({{(CMP_BITS-HYST_BITS){1'b0}}, x});
   endfunction

endpackage

`default_nettype wire

>>> src/pbb_csr.sv
// ---------------------------------------------------------------------------
// pbb_csr - configuration registers
// Write-only register file; one register written per enabled clock edge.
// ---------------------------------------------------------------------------
`default_nettype none

module pbb_csr
   import pbb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_HYSTERESIS:      cfg_in.hysteresis      = csr_wdata[HYST_BITS-1:0];
            CSR_FB_FLOOR:        cfg_in.fb_floor        = csr_wdata[FB_BITS-1:0];
            CSR_FB_CEILING:      cfg_in.fb_ceiling      = csr_wdata[FB_BITS-1:0];
            CSR_EXTEND_FIRST:    cfg_in.extend_first    = csr_wdata[SLOT_BITS-1:0];
            CSR_EXTEND_SECOND:   cfg_in.extend_second   = csr_wdata[SLOT_BITS-1:0];
            CSR_CONTRACT_FIRST:  cfg_in.contract_first  = csr_wdata[SLOT_BITS-1:0];
            CSR_CONTRACT_SECOND: cfg_in.contract_second = csr_wdata[SLOT_BITS-1:0];
            CSR_HOLD_SLOTS:      cfg_in.hold_slots      = csr_wdata[SLOT_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hysteresis      <= HYST_RST;
         cfg_ff.fb_floor        <= FLOOR_RST;
         cfg_ff.fb_ceiling      <= CEILING_RST;
         cfg_ff.extend_first    <= EXTEND_FIRST_RST;
         cfg_ff.extend_second   <= EXTEND_SECOND_RST;
         cfg_ff.contract_first  <= CONTR_FIRST_RST;
         cfg_ff.contract_second <= CONTR_SECOND_RST;
         cfg_ff.hold_slots      <= HOLD_SLOTS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> src/pbb_actuator.sv
// ---------------------------------------------------------------------------
// pbb_actuator - state and decision logic of one actuator
// Holds enable, target, limits, slot counter, chosen action and bridge drive.
// Applies one request per step and gives the drive and reached flag after it.
// ---------------------------------------------------------------------------
`default_nettype none

module pbb_actuator
   import pbb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic [SLOT_BITS-1:0] extend_slots,
   input  wire logic [SLOT_BITS-1:0] contract_slots,
   input  wire logic                 step,        // item applied this cycle
   input  wire req_kind_type         kind,
   input  wire logic                 hit,         // this actuator addressed
   input  wire logic [FB_BITS-1:0]   new_target,
   input  wire logic [FB_BITS-1:0]   new_min,
   input  wire logic [FB_BITS-1:0]   new_max,
   input  wire logic [FB_BITS-1:0]   feedback,
   output action_type                drive_nxt,
   output logic                      reached
);

   logic                 active_ff, active_in;
   logic [FB_BITS-1:0]   goal_ff, goal_in;
   logic [FB_BITS-1:0]   lower_ff, lower_in;
   logic [FB_BITS-1:0]   upper_ff, upper_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   action_type           chosen_ff, chosen_in;
   action_type           drive_ff, drive_in;

   logic signed [CMP_BITS-1:0] fb_s, h_s, lo_raw, hi_raw, lo, hi;
   logic signed [CMP_BITS-1:0] lim_lo, lim_hi, g_new;
   action_type                 choice;
   logic [SLOT_BITS-1:0]       slot_inc, period;

   // band edges: target band clamped to the feedback range, limit bands not
   always_comb begin
      fb_s   = to_cmp(feedback);
      h_s    = hyst_cmp(cfg.hysteresis);
      lo_raw = to_cmp(goal_ff) - h_s;
      hi_raw = to_cmp(goal_ff) + h_s;
      lo     = (lo_raw < to_cmp(cfg.fb_floor))   ? to_cmp(cfg.fb_floor)   : lo_raw;
      hi     = (hi_raw > to_cmp(cfg.fb_ceiling)) ? to_cmp(cfg.fb_ceiling) : hi_raw;
      lim_lo = to_cmp(lower_ff) - h_s;
      lim_hi = to_cmp(upper_ff) + h_s;
   end

   // action choice, later test wins
   always_comb begin
      choice = ACT_HOLD;
      if (fb_s <= lo)              choice = ACT_EXTEND;
      if (fb_s >= hi)              choice = ACT_CONTRACT;
      if (fb_s > lo && fb_s < hi)  choice = ACT_HOLD;
      if (fb_s <= lim_lo)          choice = ACT_EXTEND;
      if (fb_s >= lim_hi)          choice = ACT_CONTRACT;
   end

   // request handling
   always_comb begin
      active_in = active_ff;
      goal_in   = goal_ff;
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      slot_in   = slot_ff;
      chosen_in = chosen_ff;
      drive_in  = drive_ff;
      slot_inc  = slot_ff + SLOT_BITS'(1);
      period    = cfg.hold_slots;
      if (step) begin
         case (kind)
            REQ_TICK: begin
               if (active_ff) begin
                  if (slot_ff == '0) begin
                     chosen_in = choice;
                     drive_in  = choice;
                  end else begin
                     drive_in  = ACT_HOLD;
                  end
                  case (chosen_in)
                     ACT_EXTEND:   period = extend_slots;
                     ACT_CONTRACT: period = contract_slots;
                     default:      period = cfg.hold_slots;
                  endcase
                  slot_in = (slot_inc == period) ? '0 : slot_inc;
               end else begin
                  drive_in = ACT_HOLD;
               end
            end
            REQ_ENABLE: begin
               if (hit) begin
                  goal_in   = new_target;
                  lower_in  = new_min;
                  upper_in  = new_max;
                  active_in = 1'b1;
                  slot_in   = '0;
               end
            end
            REQ_DISABLE: begin
               if (hit) active_in = 1'b0;
            end
            REQ_ESTOP: begin
               active_in = 1'b0;
               drive_in  = ACT_HOLD;
            end
            default: begin
               drive_in = drive_ff;
            end
         endcase
      end
   end

   // reached flag on the unclamped band around the target after the request
   always_comb begin
      g_new   = to_cmp(goal_in);
      reached = (fb_s > g_new - h_s) && (fb_s < g_new + h_s);
   end

   assign drive_nxt = drive_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         goal_ff   <= '0;
         lower_ff  <= '0;
         upper_ff  <= '0;
         slot_ff   <= '0;
         chosen_ff <= ACT_HOLD;
         drive_ff  <= ACT_HOLD;
      end else begin
         active_ff <= active_in;
         goal_ff   <= goal_in;
         lower_ff  <= lower_in;
         upper_ff  <= upper_in;
         slot_ff   <= slot_in;
         chosen_ff <= chosen_in;
         drive_ff  <= drive_in;
      end
   end

   // a disabled actuator switches its bridge off on the next tick
   a_idle_off: assert property (@(posedge clock) disable iff (reset)
      step && kind == REQ_TICK && !active_ff |=> drive_ff == ACT_HOLD)
      else $error("bridge driven while actuator disabled");

   // gates pulse only on slot zero
   a_pulse_slot0: assert property (@(posedge clock) disable iff (reset)
      step && kind == REQ_TICK && slot_ff != '0 |=> drive_ff == ACT_HOLD)
      else $error("bridge driven outside slot zero");

   // emergency stop leaves the actuator disabled and off
   a_estop: assert property (@(posedge clock) disable iff (reset)
      step && kind == REQ_ESTOP |=> !active_ff && drive_ff == ACT_HOLD)
      else $error("emergency stop not honoured");

   // enable restarts the period
   a_enable: assert property (@(posedge clock) disable iff (reset)
      step && kind == REQ_ENABLE && hit |=> active_ff && slot_ff == '0 && $stable(drive_ff))
      else $error("enable did not restart the slot counter");

endmodule

`default_nettype wire

>>> src/pulsed_bang_bang_actuator_control.sv
// Path: an accepted request item waits in the input register, and its result is
//   then held in the result register that drives rsp_tvalid.
// Throughput: one item per cycle while the result stream is not stalled by rsp_tready;
//   each actuator applies its state update as the item advances.
// Reset: synchronous, active high; actuators disabled, targets and limits zero,
//   gates off, configuration registers back to their defaults.
// ---------------------------------------------------------------------------
// pulsed_bang_bang_actuator_control - pulsed H-bridge control of two actuators
// Input register, per-actuator decision logic and a result register; the
// stream handshake lets a new item enter while the last result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module pulsed_bang_bang_actuator_control
   import pbb_pkg::*;
#(
   parameter int ACTUATORS = ACTUATORS_DEF   // 1 or 2 actuators fitted
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // new_target, new_min, new_max, feedback_first, feedback_second, zero pad
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // req_type, actuator_sel
   input  wire logic [REQ_USER_BITS-1:0] req_tuser,
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // a0_high_left, a0_low_left, a0_high_right, a0_low_right, a1_high_left,
   // a1_low_left, a1_high_right, a1_low_right, reached_first, reached_second, zero pad
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // configuration write port
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type  cfg;
   item_type item_ff, item_in;
   logic     s1_valid_ff, s1_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic     advance;

   action_type       drive [LANES];
   logic [LANES-1:0] reached;

   pbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake: stage one moves on when the result register is free or drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // input register
   always_comb begin
      item_in.kind        = req_kind_type'(req_tuser[1:0]);
      item_in.sel         = req_tuser[2];
      item_in.new_target  = req_tdata[FB_BITS-1:0];
      item_in.new_min     = req_tdata[2*FB_BITS-1:FB_BITS];
      item_in.new_max     = req_tdata[3*FB_BITS-1:2*FB_BITS];
      item_in.feedback[0] = req_tdata[4*FB_BITS-1:3*FB_BITS];
      item_in.feedback[1] = req_tdata[5*FB_BITS-1:4*FB_BITS];
      s1_valid_in         = (req_tvalid && req_tready) || (s1_valid_ff && !advance);
   end

   // actuator lanes; an absent actuator stays disabled with a zero target
   for (genvar a = 0; a < LANES; a++) begin : g_lane
      if (a < ACTUATORS) begin : g_fitted
         pbb_actuator u_act (
            .clock          (clock),
            .reset          (reset),
            .cfg            (cfg),
            .extend_slots   ((a == 0) ? cfg.extend_first   : cfg.extend_second),
            .contract_slots ((a == 0) ? cfg.contract_first : cfg.contract_second),
            .step           (advance),
            .kind           (item_ff.kind),
            .hit            (item_ff.sel == 1'(a)),
            .new_target     (item_ff.new_target),
            .new_min        (item_ff.new_min),
            .new_max        (item_ff.new_max),
            .feedback       (item_ff.feedback[a]),
            .drive_nxt      (drive[a]),
            .reached        (reached[a])
         );
      end else begin : g_absent
         assign drive[a]   = ACT_HOLD;
         // band around a zero target reduces to feedback below the hysteresis
         assign reached[a] = item_ff.feedback[a] <
                             {{(FB_BITS-HYST_BITS){1'b0}}, cfg.hysteresis};
      end
   end

   // result word
   always_comb begin
      rsp_data_in = '0;
      for (int a = 0; a < LANES; a++) begin
         rsp_data_in[4*a]     = (drive[a] == ACT_EXTEND);
         rsp_data_in[4*a + 1] = (drive[a] == ACT_CONTRACT);
         rsp_data_in[4*a + 2] = (drive[a] == ACT_CONTRACT);
         rsp_data_in[4*a + 3] = (drive[a] == ACT_EXTEND);
      end
      rsp_data_in[4*LANES]     = reached[0];
      rsp_data_in[4*LANES + 1] = reached[1];
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) item_ff <= item_in;
      if (advance) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
